[src/rde_pkg.sv]
// Shared types and constants for the RV64 subset decode and execute unit.
package rde_pkg;

	localparam logic [6:0] OPC_RTYPE  = 7'd51;
	localparam logic [6:0] OPC_LOAD   = 7'd3;
	localparam logic [6:0] OPC_STORE  = 7'd35;
	localparam logic [6:0] OPC_BRANCH = 7'd99;
	localparam logic [6:0] OPC_OPIMM  = 7'd19;

	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_OR  = 3'd6;
	localparam logic [2:0] F3_AND = 3'd7;
	localparam logic [2:0] F3_BEQ = 3'd0;

	localparam logic [6:0] F7_BASE = 7'd0;
	localparam logic [6:0] F7_ALT  = 7'd32;

	localparam logic [51:0] IMM_SIGN_FILL = '1;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_AND,
		ALU_OR,
		ALU_SHL,
		ALU_NONE
	} alu_op_t;

	typedef struct packed {
		logic               known_opcode;
		logic               reg_write;
		logic               mem_read;
		logic               mem_write;
		logic               mem_to_reg;
		logic               is_branch;
		logic               branch_taken;
		logic [4:0]         dest_reg;
		logic signed [63:0] alu_out;
		logic               zero;
		logic [63:0]        branch_target;
		logic signed [63:0] immediate;
	} rde_result_t;

endpackage

[src/rde_in_if.sv]
// Instruction channel: instruction word, source operands and pc.
interface rde_in_if;
	logic               valid;
	logic               ready;
	logic [31:0]        instruction;
	logic signed [63:0] rs1_value;
	logic signed [63:0] rs2_value;
	logic [63:0]        pc;

	modport source (output valid, instruction, rs1_value, rs2_value, pc, input ready);
	modport sink   (input valid, instruction, rs1_value, rs2_value, pc, output ready);
endinterface

[src/rde_out_if.sv]
// Result channel: control flags, ALU result and branch information.
interface rde_out_if;
	logic               valid;
	logic               ready;
	logic               known_opcode;
	logic               reg_write;
	logic               mem_read;
	logic               mem_write;
	logic               mem_to_reg;
	logic               is_branch;
	logic               branch_taken;
	logic [4:0]         dest_reg;
	logic signed [63:0] alu_out;
	logic               zero;
	logic [63:0]        branch_target;
	logic signed [63:0] immediate;

	modport source (
		output valid, known_opcode, reg_write, mem_read, mem_write, mem_to_reg,
		       is_branch, branch_taken, dest_reg, alu_out, zero, branch_target,
		       immediate,
		input  ready
	);
	modport sink (
		input  valid, known_opcode, reg_write, mem_read, mem_write, mem_to_reg,
		       is_branch, branch_taken, dest_reg, alu_out, zero, branch_target,
		       immediate,
		output ready
	);
endinterface

[src/rde_exec.sv]
// Decode, immediate build, ALU and branch resolution for one instruction.
module rde_exec (
	input  logic [31:0]          instruction,
	input  logic signed [63:0]   rs1_value,
	input  logic signed [63:0]   rs2_value,
	input  logic [63:0]          pc,
	output rde_pkg::rde_result_t result
);
	import rde_pkg::*;

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [63:0] imm;
	logic [63:0] opa;
	logic [63:0] opb;
	logic [63:0] src2;
	logic [63:0] res;
	logic        use_imm;
	alu_op_t     op;

	assign opc = instruction[6:0];
	assign f3  = instruction[14:12];
	assign f7  = instruction[31:25];
	assign opa = rs1_value;
	assign opb = rs2_value;

	always_comb begin
		priority if (instruction[6]) begin
			imm = {{52{instruction[31]}}, instruction[7], instruction[30:25],
			       instruction[11:8], 1'b0};
		end else if (instruction[5]) begin
			imm = {{52{instruction[31]}}, instruction[31:25], instruction[11:7]};
		end else begin
			imm = {{52{instruction[31]}}, instruction[31:20]};
		end
		if (instruction[31]) begin
			imm[63:12] = IMM_SIGN_FILL;
		end
	end

	always_comb begin
		result              = '0;
		use_imm             = 1'b0;
		op                  = ALU_ADD;
		result.dest_reg     = instruction[11:7];
		unique case (opc)
			OPC_RTYPE: begin
				result.known_opcode = 1'b1;
				result.reg_write    = 1'b1;
				priority if (f7 == F7_BASE && f3 == F3_ADD) op = ALU_ADD;
				else if (f7 == F7_ALT && f3 == F3_ADD) op = ALU_SUB;
				else if (f7 == F7_BASE && f3 == F3_SLL) op = ALU_SHL;
				else if (f7 == F7_BASE && f3 == F3_AND) op = ALU_AND;
				else if (f7 == F7_BASE && f3 == F3_OR) op = ALU_OR;
				else op = ALU_NONE;
			end
			OPC_LOAD: begin
				result.known_opcode = 1'b1;
				result.reg_write    = 1'b1;
				result.mem_read     = 1'b1;
				result.mem_to_reg   = 1'b1;
				use_imm             = 1'b1;
			end
			OPC_STORE: begin
				result.known_opcode = 1'b1;
				result.mem_write    = 1'b1;
				use_imm             = 1'b1;
			end
			OPC_BRANCH: begin
				result.known_opcode = 1'b1;
				result.is_branch    = 1'b1;
				op                  = ALU_SUB;
			end
			OPC_OPIMM: begin
				result.known_opcode = 1'b1;
				result.reg_write    = 1'b1;
				use_imm             = 1'b1;
				priority if (f3 == F3_ADD) op = ALU_ADD;
				else if (f3 == F3_SLL && f7[6:1] == 6'd0) op = ALU_SHL;
				else op = ALU_NONE;
			end
			default: begin
			end
		endcase

		src2 = use_imm ? imm : opb;
		unique case (op)
			ALU_ADD: res = opa + src2;
			ALU_SUB: res = opa - src2;
			ALU_AND: res = opa & src2;
			ALU_OR:  res = opa | src2;
			ALU_SHL: res = opa << src2[5:0];
			default: res = '0;
		endcase

		result.alu_out       = res;
		result.zero          = (res == 64'd0);
		result.branch_taken  = result.is_branch &&
		                       ((f3 == F3_BEQ) ? result.zero : !result.zero);
		result.branch_target = pc + imm;
		result.immediate     = imm;
	end
endmodule

[src/riscv_decode_execute_unit_top.sv]
// Top level of the RV64 subset decode and execute unit.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    instruction, rs1_value, rs2_value, pc
//   out_ch   out  valid/ready    control flags, dest_reg, alu_out, zero,
//                                branch_target, immediate
//
// An input transfer passes through the input register, then the decode/ALU logic into the
// result register. One instruction per cycle is sustained while out_ch.ready stays high.
// Reset clears both stage valid bits; payload registers are not reset.
// A stalled output holds its result; the input stage keeps accepting while the
// result register is empty or being drained.
module riscv_decode_execute_unit_top (
	input  logic          clk,
	input  logic          arst_n,
	rde_in_if.sink        in_ch,
	rde_out_if.source     out_ch
);
	import rde_pkg::*;

	logic               valid_s1;
	logic [31:0]        instr_s1;
	logic signed [63:0] rs1_s1;
	logic signed [63:0] rs2_s1;
	logic [63:0]        pc_s1;
	logic               valid_s2;
	rde_result_t        res_s2;
	rde_result_t        res_next;
	logic               adv_s2;
	logic               adv_s1;

	assign adv_s2      = !valid_s2 || out_ch.ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign in_ch.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_ch.valid) begin
			instr_s1 <= in_ch.instruction;
			rs1_s1   <= in_ch.rs1_value;
			rs2_s1   <= in_ch.rs2_value;
			pc_s1    <= in_ch.pc;
		end
	end

	rde_exec u_exec (
		.instruction (instr_s1),
		.rs1_value   (rs1_s1),
		.rs2_value   (rs2_s1),
		.pc          (pc_s1),
		.result      (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_next;
		end
	end

	assign out_ch.valid         = valid_s2;
	assign out_ch.known_opcode  = res_s2.known_opcode;
	assign out_ch.reg_write     = res_s2.reg_write;
	assign out_ch.mem_read      = res_s2.mem_read;
	assign out_ch.mem_write     = res_s2.mem_write;
	assign out_ch.mem_to_reg    = res_s2.mem_to_reg;
	assign out_ch.is_branch     = res_s2.is_branch;
	assign out_ch.branch_taken  = res_s2.branch_taken;
	assign out_ch.dest_reg      = res_s2.dest_reg;
	assign out_ch.alu_out       = res_s2.alu_out;
	assign out_ch.zero          = res_s2.zero;
	assign out_ch.branch_target = res_s2.branch_target;
	assign out_ch.immediate     = res_s2.immediate;

	a_load_flags: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.mem_read |->
			res_s2.reg_write && res_s2.mem_to_reg && res_s2.known_opcode)
		else $error("load without writeback controls");

	a_taken_branch: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.branch_taken |-> res_s2.is_branch && res_s2.known_opcode)
		else $error("taken flag on a non-branch");

	a_unknown_clear: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.known_opcode |->
			!res_s2.reg_write && !res_s2.mem_read && !res_s2.mem_write &&
			!res_s2.mem_to_reg && !res_s2.is_branch)
		else $error("controls set for unknown opcode");

	a_s1_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("stage one item lost on advance");
endmodule

[test/tb_top.sv]
// Testbench for riscv_decode_execute_unit_top: directed and random instructions.
`timescale 1ns / 100ps

module tb_top;
	import rde_pkg::*;

	localparam int          CYCLE_LIMIT   = 400000;
	localparam logic [6:0]  OPC_UNUSED_U  = 7'h37;
	localparam logic [6:0]  OPC_UNUSED_I  = 7'h0F;
	localparam logic [6:0]  OPC_ALL_ONES  = 7'h7F;
	localparam logic [6:0]  OPC_ALL_ZERO  = 7'h00;
	localparam logic [2:0]  F3_BNE        = 3'd1;
	localparam logic [2:0]  F3_SLT        = 3'd2;
	localparam logic [2:0]  F3_LD         = 3'd3;
	localparam logic [2:0]  F3_SRL        = 3'd5;
	localparam logic [2:0]  F3_BGEU       = 3'd7;
	localparam logic [63:0] MAX_POS       = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIN_NEG       = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;

	rde_in_if  in_ch ();
	rde_out_if out_ch ();

	riscv_decode_execute_unit_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	rde_result_t issued_results[$];
	int          errors      = 0;
	int          cycle_count = 0;
	int          stall_left  = 0;
	bit          idling_on   = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idling_on || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic rde_result_t decode_and_execute(logic [31:0] w, logic [63:0] a,
			logic [63:0] b, logic [63:0] pc);
		rde_result_t r;
		logic [6:0]  opc;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [63:0] imm;
		logic [63:0] src2;
		logic [63:0] res;
		alu_op_t     op;
		logic        use_imm;
		opc = w[6:0];
		f3 = w[14:12];
		f7 = w[31:25];
		if (w[6])
			imm = {{52{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
		else if (w[5])
			imm = {{52{w[31]}}, w[31:25], w[11:7]};
		else
			imm = {{52{w[31]}}, w[31:20]};
		r = '0;
		op = ALU_ADD;
		use_imm = 1'b0;
		case (opc)
			OPC_RTYPE: begin
				r.known_opcode = 1'b1;
				r.reg_write = 1'b1;
				if (f7 == F7_BASE && f3 == F3_ADD)
					op = ALU_ADD;
				else if (f7 == F7_ALT && f3 == F3_ADD)
					op = ALU_SUB;
				else if (f7 == F7_BASE && f3 == F3_SLL)
					op = ALU_SHL;
				else if (f7 == F7_BASE && f3 == F3_AND)
					op = ALU_AND;
				else if (f7 == F7_BASE && f3 == F3_OR)
					op = ALU_OR;
				else
					op = ALU_NONE;
			end
			OPC_LOAD: begin
				r.known_opcode = 1'b1;
				r.reg_write = 1'b1;
				r.mem_read = 1'b1;
				r.mem_to_reg = 1'b1;
				use_imm = 1'b1;
			end
			OPC_STORE: begin
				r.known_opcode = 1'b1;
				r.mem_write = 1'b1;
				use_imm = 1'b1;
			end
			OPC_BRANCH: begin
				r.known_opcode = 1'b1;
				r.is_branch = 1'b1;
				op = ALU_SUB;
			end
			OPC_OPIMM: begin
				r.known_opcode = 1'b1;
				r.reg_write = 1'b1;
				use_imm = 1'b1;
				if (f3 == F3_ADD)
					op = ALU_ADD;
				else if (f3 == F3_SLL && f7[6:1] == 6'd0)
					op = ALU_SHL;
				else
					op = ALU_NONE;
			end
			default: ;
		endcase
		src2 = use_imm ? imm : b;
		case (op)
			ALU_ADD: res = a + src2;
			ALU_SUB: res = a - src2;
			ALU_AND: res = a & src2;
			ALU_OR:  res = a | src2;
			ALU_SHL: res = a << src2[5:0];
			default: res = '0;
		endcase
		r.zero = (res == 64'd0);
		r.branch_taken = r.is_branch && ((f3 == F3_BEQ) ? r.zero : !r.zero);
		r.dest_reg = w[11:7];
		r.alu_out = res;
		r.branch_target = pc + imm;
		r.immediate = imm;
		return r;
	endfunction

	function automatic logic [31:0] encode(logic [6:0] f7, logic [4:0] f5, logic [2:0] f3,
			logic [4:0] rd, logic [6:0] opc);
		logic [4:0] rs1_field;
		rs1_field = 5'($urandom);
		return {f7, f5, rs1_field, f3, rd, opc};
	endfunction

	function automatic logic [63:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return MAX_POS;
			2: return MIN_NEG;
			3: return ALL_ONES;
			4: return 64'($urandom_range(0, 64));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
		if (act !== exp) begin
			$display("%0t: %s mismatch expected %h actual %h", $time, name, exp, act);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		rde_result_t exp;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL riscv_decode_execute_unit_top");
			$finish;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (issued_results.size() == 0) begin
				$display("%0t: result transfer with nothing expected, alu_out %h",
					$time, out_ch.alu_out);
				errors++;
			end else begin
				exp = issued_results.pop_front();
				check_field("known_opcode", 64'(exp.known_opcode),
					64'(out_ch.known_opcode));
				check_field("reg_write", 64'(exp.reg_write), 64'(out_ch.reg_write));
				check_field("mem_read", 64'(exp.mem_read), 64'(out_ch.mem_read));
				check_field("mem_write", 64'(exp.mem_write), 64'(out_ch.mem_write));
				check_field("mem_to_reg", 64'(exp.mem_to_reg), 64'(out_ch.mem_to_reg));
				check_field("is_branch", 64'(exp.is_branch), 64'(out_ch.is_branch));
				check_field("branch_taken", 64'(exp.branch_taken),
					64'(out_ch.branch_taken));
				check_field("dest_reg", 64'(exp.dest_reg), 64'(out_ch.dest_reg));
				check_field("alu_out", exp.alu_out, out_ch.alu_out);
				check_field("zero", 64'(exp.zero), 64'(out_ch.zero));
				check_field("branch_target", exp.branch_target, out_ch.branch_target);
				check_field("immediate", exp.immediate, out_ch.immediate);
			end
		end
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (!idling_on) begin
			out_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			out_ch.ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	task automatic send_instr(logic [31:0] w, logic [63:0] a, logic [63:0] b, logic [63:0] pc);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.instruction <= w;
		in_ch.rs1_value <= a;
		in_ch.rs2_value <= b;
		in_ch.pc <= pc;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		issued_results.push_back(decode_and_execute(w, a, b, pc));
	endtask

	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		while (issued_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_random_instr();
		logic [31:0] w;
		logic [63:0] a;
		logic [63:0] b;
		int          k;
		w = $urandom;
		a = rand_operand();
		b = rand_operand();
		k = $urandom_range(0, 99);
		if (k < 25) begin
			w[6:0] = OPC_RTYPE;
			case ($urandom_range(0, 4))
				0: begin w[31:25] = F7_BASE; w[14:12] = F3_ADD; end
				1: begin w[31:25] = F7_ALT;  w[14:12] = F3_ADD; end
				2: begin w[31:25] = F7_BASE; w[14:12] = F3_SLL; end
				3: begin w[31:25] = F7_BASE; w[14:12] = F3_AND; end
				default: begin w[31:25] = F7_BASE; w[14:12] = F3_OR; end
			endcase
		end else if (k < 30) begin
			w[6:0] = OPC_RTYPE;
		end else if (k < 40) begin
			w[6:0] = OPC_LOAD;
		end else if (k < 50) begin
			w[6:0] = OPC_STORE;
		end else if (k < 65) begin
			w[6:0] = OPC_BRANCH;
			if ($urandom_range(0, 3) != 0)
				w[14:12] = 3'($urandom_range(0, 1));
			if ($urandom_range(0, 1) == 0)
				b = a;
		end else if (k < 78) begin
			w[6:0] = OPC_OPIMM;
			w[14:12] = F3_ADD;
		end else if (k < 88) begin
			w[6:0] = OPC_OPIMM;
			w[14:12] = F3_SLL;
			w[31:26] = 6'd0;
		end else if (k < 93) begin
			w[6:0] = OPC_OPIMM;
		end
		send_instr(w, a, b, {$urandom, $urandom});
	endtask

	task automatic test_rtype();
		send_instr(encode(F7_BASE, 5'd1, F3_ADD, 5'd0, OPC_RTYPE), MAX_POS, 64'd1, 64'h1000);
		send_instr(encode(F7_ALT, 5'd2, F3_ADD, 5'd31, OPC_RTYPE), MIN_NEG, 64'd1, 64'h1004);
		send_instr(encode(F7_BASE, 5'd3, F3_SLL, 5'd5, OPC_RTYPE), 64'd1, ALL_ONES, 64'h1008);
		send_instr(encode(F7_BASE, 5'd4, F3_AND, 5'd6, OPC_RTYPE), ALL_ONES,
			64'hA5A5_5A5A_F0F0_0F0F, 64'h100C);
		send_instr(encode(F7_BASE, 5'd5, F3_OR, 5'd7, OPC_RTYPE), 64'd0, 64'd0, 64'h1010);
		send_instr(encode(7'h7F, 5'd6, F3_SLT, 5'd8, OPC_RTYPE), 64'd3, 64'd4, 64'h1014);
	endtask

	task automatic test_load_store();
		send_instr(encode(7'h7F, 5'h1F, F3_LD, 5'd9, OPC_LOAD), 64'd8, 64'd0, 64'h2000);
		send_instr(encode(7'h3F, 5'h1F, F3_LD, 5'd10, OPC_LOAD), MAX_POS, 64'd0, 64'h2004);
		send_instr(encode(7'h40, 5'd11, F3_LD, 5'h00, OPC_STORE), 64'd0, ALL_ONES, 64'h2008);
	endtask

	task automatic test_branches();
		send_instr(encode(7'h00, 5'd1, F3_BEQ, 5'h10, OPC_BRANCH), MIN_NEG, MIN_NEG, 64'h3000);
		send_instr(encode(7'h3F, 5'd1, F3_BEQ, 5'h1F, OPC_BRANCH), 64'd1, 64'd2, 64'h3004);
		send_instr(encode(7'h7F, 5'd2, F3_BNE, 5'h1E, OPC_BRANCH), ALL_ONES, ALL_ONES,
			64'h3008);
		send_instr(encode(7'h01, 5'd2, F3_BNE, 5'h02, OPC_BRANCH), MAX_POS, MIN_NEG, 64'h300C);
		send_instr(encode(7'h40, 5'd3, F3_BGEU, 5'h00, OPC_BRANCH), 64'd5, 64'd6, 64'h800);
	endtask

	task automatic test_opimm();
		send_instr(encode(7'h40, 5'h00, F3_ADD, 5'd12, OPC_OPIMM), MIN_NEG, 64'd0, 64'h4000);
		send_instr(encode(7'h01, 5'h1F, F3_SLL, 5'd13, OPC_OPIMM), 64'd1, 64'd0, 64'h4004);
		send_instr(encode(7'h02, 5'h01, F3_SLL, 5'd14, OPC_OPIMM), ALL_ONES, 64'd0, 64'h4008);
		send_instr(encode(7'h00, 5'h04, F3_SRL, 5'd15, OPC_OPIMM), ALL_ONES, 64'd0, 64'h400C);
		send_instr(encode(7'h01, 5'h00, F3_SLL, 5'd16, OPC_OPIMM), MAX_POS, 64'd0, 64'h4010);
	endtask

	task automatic test_unknown_opcode();
		send_instr(32'h0000_0000, 64'd7, ALL_ONES - 64'd6, 64'h0);
		send_instr(32'hFFFF_FFFF, ALL_ONES, ALL_ONES, ALL_ONES);
		send_instr(encode(7'h55, 5'h0A, F3_SLT, 5'h15, OPC_UNUSED_U), MAX_POS, 64'd1, MAX_POS);
		send_instr(encode(7'h2A, 5'h15, F3_SRL, 5'h0A, OPC_UNUSED_I), 64'd1, 64'd2, MIN_NEG);
		send_instr(encode(7'h7F, 5'h1F, F3_BGEU, 5'h1F, OPC_ALL_ZERO), 64'd0, 64'd0, ALL_ONES);
		send_instr(encode(7'h00, 5'h00, F3_ADD, 5'h00, OPC_ALL_ONES), 64'd0, 64'd0, 64'd0);
	endtask

	task automatic test_streaming(int count);
		idling_on = 1'b0;
		repeat (count) send_random_instr();
		wait_drain();
		idling_on = 1'b1;
	endtask

	task automatic test_drain_pause();
		repeat (20) send_random_instr();
		wait_drain();
		repeat (20) send_random_instr();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			send_random_instr();
			if (i % 250 == 249)
				wait_drain();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.instruction = '0;
		in_ch.rs1_value = '0;
		in_ch.rs2_value = '0;
		in_ch.pc = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_rtype();
		test_load_store();
		test_branches();
		test_opimm();
		test_unknown_opcode();
		test_streaming(150);
		test_drain_pause();
		test_random(910);
		wait_drain();
		if (errors == 0)
			$display("PASS riscv_decode_execute_unit_top");
		else
			$display("FAIL riscv_decode_execute_unit_top");
		$finish;
	end

endmodule

[riscv_decode_execute_unit_top.f]
src/rde_pkg.sv
src/rde_in_if.sv
src/rde_out_if.sv
src/rde_exec.sv
src/riscv_decode_execute_unit_top.sv
test/tb_top.sv
